FILE: rtl/utf8_lenient_decoder_unit_defines.svh
// assertion macros for the utf8 lenient decoder unit
`ifndef UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH
`define UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define U8LD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8ld assertion failed");
`define U8LD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8ld assertion failed");
`else
`define U8LD_ASSERT_SAME(label, ante, cons)
`define U8LD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/u8ld_pkg.sv
// types and helper functions shared by the utf8 lenient decoder unit
`timescale 1ns / 1ps

package u8ld_pkg;

    localparam int unsigned CpWidth  = 21;
    localparam int unsigned MaxRes   = 3;

    typedef logic [CpWidth-1:0] cp_t;

    typedef struct packed {
        logic [1:0]          cnt;
        logic [MaxRes-1:0]   fin;
        cp_t [MaxRes-1:0]    cp;
    } res_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7])
        begin
            len = 3'd1;
        end
        else if (b[7:5] == 3'b110)
        begin
            len = 3'd2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            len = 3'd3;
        end
        else if (b[7:4] == 4'b1111)
        begin
            len = 3'd4;
        end
        else
        begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic cp_t lead_payload(input logic [7:0] b, input logic [2:0] len);
        cp_t p;
        case (len)
            3'd2:    p = {16'd0, b[4:0]};
            3'd3:    p = {17'd0, b[3:0]};
            3'd4:    p = {18'd0, b[2:0]};
            default: p = {13'd0, b};
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/utf8_lenient_decoder_unit.sv
// top level of the utf8 lenient decoder unit
//
//  channel  signals                          word
//  input    in_valid, in_ready               byte_in, text_end
//  output   out_valid, out_ready             code_point, final_point
//
// one byte is taken per cycle into the input register while the bank can load it,
// then decoded into the result bank; a completed sequence is offered at the output
// from the bank. an end flag inside an open sequence gives up to three words, one per
// cycle while out_ready holds high; the input register waits while the bank drains.
// reset clears the sequence state, input register and result bank.
// a stalled output holds the bank; one further byte then waits in the input register.
`timescale 1ns / 1ps

module utf8_lenient_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        text_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        final_point
);
    import u8ld_pkg::*;

    logic       ivalid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       load_ok;
    logic       step;
    res_t       res;

    assign step     = ivalid_reg && load_ok;
    assign in_ready = !ivalid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
            end_reg  <= text_end;
        end
    end

    u8ld_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .byte_val (byte_reg),
        .end_val  (end_reg),
        .res      (res)
    );

    u8ld_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .res         (res),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .final_point (final_point)
    );

endmodule

FILE: rtl/u8ld_decode.sv
// sequence state and single-pass decode of one byte into up to three code points
`timescale 1ns / 1ps

module u8ld_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     byte_val,
    input  logic           end_val,
    output u8ld_pkg::res_t res
);
    import u8ld_pkg::*;

    cp_t        partial_reg, partial_next;
    logic [1:0] need_reg, need_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;

    logic [2:0] len_b;
    logic [2:0] len_h1;
    cp_t        shifted;
    logic [1:0] need_dec;

    always_comb
    begin
        len_b    = lead_length(byte_val);
        len_h1   = lead_length(held1_reg);
        shifted  = {partial_reg[CpWidth-7:0], byte_val[5:0]};
        need_dec = need_reg - 2'd1;

        partial_next = partial_reg;
        need_next    = need_reg;
        count_next   = count_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        res          = '0;

        if (need_reg == 2'd0)
        begin
            if (end_val || len_b == 3'd1)
            begin
                res.cnt    = 2'd1;
                res.cp[0]  = {13'd0, byte_val};
                res.fin[0] = end_val;
            end
            else
            begin
                partial_next = lead_payload(byte_val, len_b);
                need_next    = 2'(len_b - 3'd1);
                held0_next   = byte_val;
                count_next   = 2'd1;
            end
        end
        else if (need_dec == 2'd0)
        begin
            res.cnt      = 2'd1;
            res.cp[0]    = shifted;
            res.fin[0]   = end_val;
            partial_next = '0;
            need_next    = 2'd0;
            count_next   = 2'd0;
        end
        else if (end_val)
        begin
            // flush of an incomplete sequence
            partial_next = '0;
            need_next    = 2'd0;
            count_next   = 2'd0;
            case (count_reg)
                2'd0:
                begin
                    res.cnt    = 2'd1;
                    res.cp[0]  = {13'd0, byte_val};
                    res.fin[0] = 1'b1;
                end
                2'd1:
                begin
                    res.cnt    = 2'd2;
                    res.cp[0]  = {13'd0, held0_reg};
                    res.cp[1]  = {13'd0, byte_val};
                    res.fin[1] = 1'b1;
                end
                default:
                begin
                    res.cp[0] = {13'd0, held0_reg};
                    if (len_h1 == 3'd2)
                    begin
                        res.cnt    = 2'd2;
                        res.cp[1]  = {10'd0, held1_reg[4:0], byte_val[5:0]};
                        res.fin[1] = 1'b1;
                    end
                    else
                    begin
                        res.cnt    = 2'd3;
                        res.cp[1]  = {13'd0, held1_reg};
                        res.cp[2]  = {13'd0, byte_val};
                        res.fin[2] = 1'b1;
                    end
                end
            endcase
        end
        else
        begin
            partial_next = shifted;
            need_next    = need_dec;
            if (count_reg != 2'd3)
            begin
                count_next = count_reg + 2'd1;
            end
            if (count_reg == 2'd0)
            begin
                held0_next = byte_val;
            end
            else if (count_reg == 2'd1)
            begin
                held1_next = byte_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            need_reg    <= 2'd0;
            count_reg   <= 2'd0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            need_reg    <= need_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

FILE: rtl/u8ld_out_queue.sv
// result register bank that hands out up to three code points one word at a time
`timescale 1ns / 1ps
`include "utf8_lenient_decoder_unit_defines.svh"

module u8ld_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  u8ld_pkg::res_t res,
    output logic           load_ok,
    output logic           out_valid,
    input  logic           out_ready,
    output u8ld_pkg::cp_t  code_point,
    output logic           final_point
);
    import u8ld_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    res_t       slot_reg;
    logic       out_fire;

    assign out_valid   = (cnt_reg != 2'd0);
    assign out_fire    = out_valid && out_ready;
    assign load_ok     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign code_point  = slot_reg.cp[rd_reg];
    assign final_point = slot_reg.fin[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load)
        begin
            cnt_next = res.cnt;
            rd_next  = 2'd0;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= res;
        end
    end

    `U8LD_ASSERT_NEXT(a_load_shows, load && res.cnt != 2'd0, out_valid && rd_reg == 2'd0)
    `U8LD_ASSERT_NEXT(a_stall_holds, !load && out_valid && !out_ready, $stable({cnt_reg, rd_reg}))
    `U8LD_ASSERT_SAME(a_load_room, load, cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready))
    `U8LD_ASSERT_SAME(a_rd_bound, out_valid, ({1'b0, rd_reg} + {1'b0, cnt_reg}) <= 3'd3)

endmodule
